### src/cle_pkg.sv
// Shared types and constants for the circular list engine.
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

    // Field widths fixed by the item format
    localparam int CMD_W       = 3;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = 5;
    localparam int OUT_TDATA_W = 72;

    // Command codes carried on the input tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_FWD    = 3'd2,
        CMD_BACK   = 3'd3,
        CMD_DUMP   = 3'd4
    } cmd_t;

    // Sequencer states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_INS_LINK = 8'b0000_0010,
        ST_INS_TAIL = 8'b0000_0100,
        ST_DEL_CHK  = 8'b0000_1000,
        ST_ROT      = 8'b0001_0000,
        ST_FETCH    = 8'b0010_0000,
        ST_RESULT   = 8'b0100_0000,
        ST_DUMP     = 8'b1000_0000
    } state_t;

    // One result transaction
    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] item;
        logic                    last;
        logic signed [VAL_W-1:0] head;
        logic [CNT_W-1:0]        count;
        logic                    empty;
    } res_t;

endpackage

`default_nettype wire

### src/circular_list_engine_unit.sv
// Circular doubly linked list held in synchronous node, next and prev memories.
//
//  channel | dir | handshake                   | payload
//  --------+-----+-----------------------------+----------------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready | tuser: command; tdata: value
//  m_axis  | out | m_axis_tvalid/m_axis_tready | tdata: ok,item,head,count,empty; tlast
//
//  A delete reads and compares the entries from the head, one memory read per cycle,
//  until it finds a match or has compared every entry. The three memories share one
//  read port. One command is in work at a time; s_axis_tready is high whenever the
//  sequencer is idle, even while the last result still waits in the output register.
//  A stalled m_axis holds the dump walk in place. Reset clears the slot map, head,
//  count and control; memory contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module circular_list_engine_unit
    import cle_pkg::*;
#(
    parameter int CAPACITY = 16
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output      logic                    s_axis_tready,
    input  wire logic signed [VAL_W-1:0] s_axis_tdata,   // [31:0] value
    input  wire logic [CMD_W-1:0]        s_axis_tuser,   // [2:0] command
    output      logic                    m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output      logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [0] ok, [32:1] item_value,
                                                         // [64:33] head_value,
                                                         // [69:65] count, [70] empty_res,
                                                         // [71] zero
    output      logic                    m_axis_tlast
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Storage
    logic signed [VAL_W-1:0] node_mem [CAPACITY];
    logic [SW-1:0]           next_mem [CAPACITY];
    logic [SW-1:0]           prev_mem [CAPACITY];

    // Control registers
    state_t                  state_reg, state_next;
    logic [SW-1:0]           head_reg, head_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CAPACITY-1:0]     used_reg, used_next;
    logic [SW-1:0]           cur_reg, cur_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;

    // Working registers for the command in progress
    logic [SW-1:0]           slot_reg, slot_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    cmd_t                    cmd_reg, cmd_next;
    logic                    ok_reg, ok_next;
    logic signed [VAL_W-1:0] dhead_reg, dhead_next;
    res_t                    res_reg, res_next;

    // Memory read data
    logic signed [VAL_W-1:0] node_rd_reg;
    logic [SW-1:0]           next_rd_reg;
    logic [SW-1:0]           prev_rd_reg;

    // Memory port controls
    logic                    rd_en;
    logic [SW-1:0]           rd_addr;
    logic                    node_we;
    logic [SW-1:0]           node_wa;
    logic signed [VAL_W-1:0] node_wd;
    logic                    next_we;
    logic [SW-1:0]           next_wa;
    logic [SW-1:0]           next_wd;
    logic                    prev_we;
    logic [SW-1:0]           prev_wa;
    logic [SW-1:0]           prev_wd;

    logic                    s_accept;
    logic                    out_free;
    logic [SW-1:0]           free_slot;
    cmd_t                    cmd_in;
    logic                    dump_last;

    // Find the lowest free slot
    function automatic logic [SW-1:0] first_free(input logic [CAPACITY-1:0] used);
        logic [SW-1:0] slot;
        slot = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (!used[k]) begin
                slot = SW'(k);
            end
        end
        return slot;
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign free_slot     = first_free(used_reg);
    assign cmd_in        = cmd_t'(s_axis_tuser);
    assign dump_last     = ((idx_reg + CW'(1)) == count_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tdata  = {1'b0, res_reg.empty, res_reg.count, res_reg.head,
                            res_reg.item, res_reg.ok};

    // Sequence each command through the memories
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        val_next       = val_reg;
        cmd_next       = cmd_reg;
        ok_next        = ok_reg;
        dhead_next     = dhead_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        rd_en   = 1'b0;
        rd_addr = head_reg;
        node_we = 1'b0;
        node_wa = slot_reg;
        node_wd = val_reg;
        next_we = 1'b0;
        next_wa = slot_reg;
        next_wd = head_reg;
        prev_we = 1'b0;
        prev_wa = head_reg;
        prev_wd = slot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    // Latch the transaction and prefetch the head entry
                    cmd_next   = cmd_in;
                    val_next   = s_axis_tdata;
                    slot_next  = free_slot;
                    ok_next    = 1'b0;
                    cur_next   = head_reg;
                    idx_next   = '0;
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = ST_FETCH;
                    unique case (cmd_in)
                        CMD_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                ok_next = 1'b0;
                            end
                            else if (count_reg == '0)
                            begin
                                // First element links to itself
                                node_we              = 1'b1;
                                node_wa              = free_slot;
                                node_wd              = s_axis_tdata;
                                next_we              = 1'b1;
                                next_wa              = free_slot;
                                next_wd              = free_slot;
                                prev_we              = 1'b1;
                                prev_wa              = free_slot;
                                prev_wd              = free_slot;
                                head_next            = free_slot;
                                used_next[free_slot] = 1'b1;
                                count_next           = count_reg + CW'(1);
                                ok_next              = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_INS_LINK;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_DEL_CHK;
                            end
                        end
                        CMD_FWD, CMD_BACK:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                state_next = ST_ROT;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_INS_LINK:
            begin
                // Tail now known: hook the new node after it
                next_we    = 1'b1;
                next_wa    = prev_rd_reg;
                next_wd    = slot_reg;
                prev_we    = 1'b1;
                prev_wa    = slot_reg;
                prev_wd    = prev_rd_reg;
                node_we    = 1'b1;
                node_wa    = slot_reg;
                node_wd    = val_reg;
                state_next = ST_INS_TAIL;
            end

            ST_INS_TAIL:
            begin
                // Close the ring back to the head
                next_we             = 1'b1;
                next_wa             = slot_reg;
                next_wd             = head_reg;
                prev_we             = 1'b1;
                prev_wa             = head_reg;
                prev_wd             = slot_reg;
                used_next[slot_reg] = 1'b1;
                count_next          = count_reg + CW'(1);
                ok_next             = 1'b1;
                state_next          = ST_FETCH;
            end

            ST_DEL_CHK:
            begin
                if (node_rd_reg == val_reg)
                begin
                    // Unlink the match
                    next_we            = 1'b1;
                    next_wa            = prev_rd_reg;
                    next_wd            = next_rd_reg;
                    prev_we            = 1'b1;
                    prev_wa            = next_rd_reg;
                    prev_wd            = prev_rd_reg;
                    used_next[cur_reg] = 1'b0;
                    count_next         = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        head_next = '0;
                    end
                    else if (cur_reg == head_reg)
                    begin
                        head_next = next_rd_reg;
                    end
                    ok_next    = 1'b1;
                    state_next = ST_FETCH;
                end
                else if (dump_last)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    // Advance the search one link
                    idx_next = idx_reg + CW'(1);
                    cur_next = next_rd_reg;
                    rd_en    = 1'b1;
                    rd_addr  = next_rd_reg;
                end
            end

            ST_ROT:
            begin
                head_next  = (cmd_reg == CMD_FWD) ? next_rd_reg : prev_rd_reg;
                ok_next    = 1'b1;
                state_next = ST_FETCH;
            end

            ST_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    res_next.ok    = ok_reg;
                    res_next.item  = '0;
                    res_next.last  = 1'b1;
                    res_next.head  = (count_reg != '0) ? node_rd_reg : '0;
                    res_next.count = CNT_W'(count_reg);
                    res_next.empty = (count_reg == '0);
                    state_next     = ST_IDLE;
                end
            end

            ST_DUMP:
            begin
                if (out_free)
                begin
                    // Emit one element and fetch the next
                    out_valid_next = 1'b1;
                    res_next.ok    = 1'b1;
                    res_next.item  = node_rd_reg;
                    res_next.last  = dump_last;
                    res_next.head  = (idx_reg == '0) ? node_rd_reg : dhead_reg;
                    res_next.count = CNT_W'(count_reg);
                    res_next.empty = 1'b0;
                    if (idx_reg == '0)
                    begin
                        dhead_next = node_rd_reg;
                    end
                    if (dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                        rd_en    = 1'b1;
                        rd_addr  = next_rd_reg;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            used_reg      <= '0;
            cur_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            cur_reg       <= cur_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        val_reg   <= val_next;
        cmd_reg   <= cmd_next;
        ok_reg    <= ok_next;
        dhead_reg <= dhead_next;
        res_reg   <= res_next;
    end

    // Node, next and prev memories: one write port each, shared read address
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_wa] <= node_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (rd_en)
        begin
            node_rd_reg <= node_mem[rd_addr];
            next_rd_reg <= next_mem[rd_addr];
            prev_rd_reg <= prev_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### tb/circular_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the circular list engine: stream driver, list model, checker.
module circular_list_engine_unit_tb;
    import cle_pkg::*;

    localparam int DEPTH         = 16;
    localparam int RANDOM_ITEMS  = 80;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;

    // Command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    // Receiver stall patterns
    localparam int RX_OPEN     = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_CHOKED   = 3;

    // Random stimulus segments
    localparam int SEG_FILL  = 0;
    localparam int SEG_DRAIN = 1;
    localparam int SEG_MIX   = 2;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        bit                      drain;
    } list_op_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic signed [VAL_W-1:0] s_axis_tdata = '0;
    logic [CMD_W-1:0]        s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;

    // Operations waiting to be sent and list reports waiting to arrive
    list_op_t                op_queue[$];
    res_t                    list_reports_q[$];
    logic signed [VAL_W-1:0] shadow_vals[$];
    bit                      next_drain = 1'b0;

    // Model of the list
    logic signed [VAL_W-1:0] lst_val [DEPTH] = '{default: '0};
    logic [3:0]              lst_next [DEPTH] = '{default: '0};
    logic [3:0]              lst_prev [DEPTH] = '{default: '0};
    logic [DEPTH-1:0]        lst_used = '0;
    logic [3:0]              lst_head = '0;
    logic [CNT_W-1:0]        lst_count = '0;

    bit   took_op = 1'b0;
    int   mismatches = 0;
    int   cycles = 0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   rx_mode = RX_OPEN;
    int   rx_left = 0;
    int   rx_phase = 0;
    res_t got_rep;
    res_t want_rep;

    circular_list_engine_unit #(.CAPACITY(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] value
        .s_axis_tuser  (s_axis_tuser),   // [2:0] command
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [0] ok, [32:1] item_value, [64:33] head_value,
                                         // [69:65] count, [70] empty_res, [71] zero
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Record one list report, taking head and count from the model as it stands
    task automatic push_report(input logic ok, input logic signed [VAL_W-1:0] item,
                               input logic last);
        res_t r;
        r.ok    = ok;
        r.item  = item;
        r.last  = last;
        r.head  = (lst_count != 0) ? lst_val[lst_head] : '0;
        r.count = lst_count;
        r.empty = (lst_count == 0);
        list_reports_q.push_back(r);
    endtask

    // Apply one command to the model and queue the reports it causes
    task automatic apply_list_op(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] v);
        logic       ok;
        logic [3:0] slot;
        logic [3:0] cur;
        logic [3:0] p;
        logic [3:0] n;
        bit         hit;
        ok = 1'b0;
        case (cmd)
            CMD_INSERT:
            begin
                if (lst_count < DEPTH)
                begin
                    slot = '0;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!lst_used[i])
                            slot = i[3:0];
                    lst_used[slot] = 1'b1;
                    lst_val[slot]  = v;
                    if (lst_count == 0)
                    begin
                        lst_head       = slot;
                        lst_next[slot] = slot;
                        lst_prev[slot] = slot;
                    end
                    else
                    begin
                        p                  = lst_prev[lst_head];
                        lst_next[p]        = slot;
                        lst_prev[slot]     = p;
                        lst_next[slot]     = lst_head;
                        lst_prev[lst_head] = slot;
                    end
                    lst_count = lst_count + 1'b1;
                    ok = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                cur = lst_head;
                hit = 1'b0;
                for (int i = 0; i < lst_count; i++)
                begin
                    if (!hit && lst_val[cur] == v)
                    begin
                        hit = 1'b1;
                        p = lst_prev[cur];
                        n = lst_next[cur];
                        if (cur == lst_head)
                            lst_head = n;
                        lst_next[p]   = n;
                        lst_prev[n]   = p;
                        lst_used[cur] = 1'b0;
                    end
                    else if (!hit)
                    begin
                        cur = lst_next[cur];
                    end
                end
                if (hit)
                begin
                    lst_count = lst_count - 1'b1;
                    if (lst_count == 0)
                        lst_head = '0;
                    ok = 1'b1;
                end
            end
            CMD_FWD:
            begin
                if (lst_count >= 2)
                begin
                    lst_head = lst_next[lst_head];
                    ok = 1'b1;
                end
            end
            CMD_BACK:
            begin
                if (lst_count >= 2)
                begin
                    lst_head = lst_prev[lst_head];
                    ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        // Walk the ring from the head on a dump; everything else reports once
        if (cmd == CMD_DUMP && lst_count != 0)
        begin
            cur = lst_head;
            for (int i = 0; i < lst_count; i++)
            begin
                push_report(1'b1, lst_val[cur], (i + 1 == lst_count));
                cur = lst_next[cur];
            end
        end
        else
        begin
            push_report(ok, '0, 1'b1);
        end
    endtask

    task automatic note_mismatch(input string what, input res_t want, input res_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch (%s): expected ok=%0b item=%0d last=%0b head=%0d count=%0d empty=%0b, got ok=%0b item=%0d last=%0b head=%0d count=%0d empty=%0b",
                     $realtime, what, want.ok, want.item, want.last, want.head, want.count,
                     want.empty, got.ok, got.item, got.last, got.head, got.count, got.empty);
    endtask

    // Queue one operation and track the values the list should hold
    task automatic queue_op(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] v);
        list_op_t op;
        int       idx;
        op.cmd   = cmd;
        op.value = v;
        op.drain = next_drain;
        next_drain = 1'b0;
        op_queue.push_back(op);
        if (cmd == CMD_INSERT && shadow_vals.size() < DEPTH)
        begin
            shadow_vals.push_back(v);
        end
        else if (cmd == CMD_DELETE)
        begin
            idx = -1;
            foreach (shadow_vals[i])
                if (idx < 0 && shadow_vals[i] == v)
                    idx = i;
            if (idx >= 0)
                shadow_vals.delete(idx);
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return $signed($urandom_range(0, 7)) - 32'sd3;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_delete_value();
        if (shadow_vals.size() > 0 && $urandom_range(0, 4) != 0)
            return shadow_vals[$urandom_range(0, shadow_vals.size() - 1)];
        return pick_value();
    endfunction

    // Check result transactions and predict each accepted command
    always @(posedge clk)
    begin
        took_op = 1'b0;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_rep.ok    = m_axis_tdata[0];
                got_rep.item  = m_axis_tdata[32:1];
                got_rep.head  = m_axis_tdata[64:33];
                got_rep.count = m_axis_tdata[69:65];
                got_rep.empty = m_axis_tdata[70];
                got_rep.last  = m_axis_tlast;
                if (list_reports_q.size() == 0)
                begin
                    note_mismatch("no result expected", '0, got_rep);
                end
                else
                begin
                    want_rep = list_reports_q.pop_front();
                    if (got_rep.ok !== want_rep.ok)
                        note_mismatch("ok", want_rep, got_rep);
                    if (got_rep.item !== want_rep.item)
                        note_mismatch("item_value", want_rep, got_rep);
                    if (got_rep.last !== want_rep.last)
                        note_mismatch("last", want_rep, got_rep);
                    if (got_rep.head !== want_rep.head)
                        note_mismatch("head_value", want_rep, got_rep);
                    if (got_rep.count !== want_rep.count)
                        note_mismatch("count", want_rep, got_rep);
                    if (got_rep.empty !== want_rep.empty)
                        note_mismatch("empty_res", want_rep, got_rep);
                    if (m_axis_tdata[71] !== 1'b0)
                        note_mismatch("pad bit", want_rep, got_rep);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                took_op = 1'b1;
                apply_list_op(s_axis_tuser, s_axis_tdata);
            end
        end
    end

    // Drive commands in bursts; hold a marked command until all reports are in
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (took_op)
            begin
                op_queue.delete(0);
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30)
                                                             : $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            if (s_axis_tvalid && !took_op)
            begin
                // hold the transaction until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (op_queue.size() > 0 &&
                     !(op_queue[0].drain && list_reports_q.size() != 0))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= op_queue[0].cmd;
                s_axis_tdata  <= op_queue[0].value;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Stall the result side on a changing pattern
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(RX_OPEN, RX_CHOKED);
            rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_COIN:     m_axis_tready <= $urandom_range(0, 1);
            RX_PERIODIC: m_axis_tready <= (rx_phase % 4) != 3;
            default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int seg;
        int n;
        int r;
        int directed_n;
        bit first_seg;

        // Directed: empty-list no-ops, single element, rotation, deletes, unknown codes
        queue_op(CMD_DUMP, 32'sd0);
        queue_op(CMD_DELETE, 32'sd5);
        queue_op(CMD_FWD, 32'sd0);
        queue_op(CMD_BACK, 32'sd0);
        queue_op(CMD_INSERT, 32'sh8000_0000);
        queue_op(CMD_FWD, 32'sd0);
        queue_op(CMD_BACK, 32'sd0);
        queue_op(CMD_DUMP, 32'sd0);
        queue_op(CMD_INSERT, 32'sh7fff_ffff);
        queue_op(CMD_INSERT, -32'sd1);
        queue_op(CMD_INSERT, 32'sd0);
        queue_op(CMD_FWD, 32'sh7fff_ffff);
        queue_op(CMD_BACK, -32'sd1);
        queue_op(CMD_BACK, 32'sd0);
        queue_op(CMD_DUMP, 32'sd0);
        queue_op(CMD_DELETE, 32'sh7fff_ffff);
        queue_op(CMD_DELETE, 32'sd12345);
        queue_op(CMD_DELETE, 32'sd0);
        queue_op(CMD_RSVD_5, 32'sd0);
        queue_op(CMD_RSVD_6, -32'sd1);
        queue_op(CMD_RSVD_7, 32'sh8000_0000);
        queue_op(CMD_INSERT, 32'sd1);
        queue_op(CMD_DUMP, 32'sd0);
        directed_n = op_queue.size();

        // Random: fill to capacity, drain to empty, and mixed traffic
        first_seg = 1'b1;
        while (op_queue.size() < directed_n + RANDOM_ITEMS)
        begin
            seg = first_seg ? SEG_FILL : $urandom_range(SEG_FILL, SEG_MIX + 1);
            next_drain = first_seg || ($urandom_range(0, 2) == 0);
            first_seg = 1'b0;
            case (seg)
                SEG_FILL:
                begin
                    while (shadow_vals.size() < DEPTH)
                        queue_op(CMD_INSERT, pick_value());
                    repeat ($urandom_range(1, 2))
                        queue_op(CMD_INSERT, pick_value());
                    queue_op(CMD_DUMP, pick_value());
                end
                SEG_DRAIN:
                begin
                    while (shadow_vals.size() > 0)
                        queue_op(CMD_DELETE,
                                 shadow_vals[$urandom_range(0, shadow_vals.size() - 1)]);
                    queue_op(CMD_DELETE, pick_value());
                end
                default:
                begin
                    n = $urandom_range(8, 20);
                    repeat (n)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 35)
                            queue_op(CMD_INSERT, pick_value());
                        else if (r < 55)
                            queue_op(CMD_DELETE, pick_delete_value());
                        else if (r < 67)
                            queue_op(CMD_FWD, pick_value());
                        else if (r < 79)
                            queue_op(CMD_BACK, pick_value());
                        else if (r < 94)
                            queue_op(CMD_DUMP, pick_value());
                        else
                            case ($urandom_range(0, 2))
                                0:       queue_op(CMD_RSVD_5, pick_value());
                                1:       queue_op(CMD_RSVD_6, pick_value());
                                default: queue_op(CMD_RSVD_7, pick_value());
                            endcase
                    end
                end
            endcase
        end

        // Release reset, then wait for all traffic to finish
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        while (op_queue.size() != 0)
            @(posedge clk);
        while (list_reports_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (list_reports_q.size() != 0)
            mismatches++;

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
src/cle_pkg.sv
src/circular_list_engine_unit.sv
tb/circular_list_engine_unit_tb.sv
